[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int OPC_W  = 1;
  localparam int ORD_W  = 4;
  localparam int PAGE_W = 10;
  localparam int STAT_W = 2;
  localparam int TOP_RESET = 10;
  // Largest zone order the tree is built for; the zone never exceeds it.
  localparam int ORDER_CAP = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_BAD_REQ     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_ROOT_EVAL,
    DP_DESC_RD,
    DP_DESC_STEP,
    DP_SPLIT_INIT,
    DP_CHK_RD,
    DP_CHK_UP,
    DP_MRG_INIT,
    DP_MRG_RD,
    DP_MRG_TAKE,
    DP_FINAL,
    DP_UP_A,
    DP_UP_B,
    DP_UP_W,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_req;
    logic is_free;
    logic clr_last;
    logic found;
    logic at_top;
    logic at_fo;
    logic below_split;
    logic chk_hit;
    logic buddy_free;
  } dp_sts_t;

endpackage

[sv/bpa_if.sv]
// ----------------------------------------------------------------------------
// bpa_if
// Request and response channels of the buddy page allocator.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [ORD_W-1:0]  block_order;
  logic [PAGE_W-1:0] page_index;
  modport source(output valid, opcode, block_order, page_index, input ready);
  modport sink(input valid, opcode, block_order, page_index, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] granted_index;
  modport source(output valid, status, granted_index, input ready);
  modport sink(input valid, status, granted_index, output ready);
endinterface

[sv/buddy_page_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over zone-relative page indices.
// ----------------------------------------------------------------------------
// Each request beat on in_req carries an opcode (allocate or free), a block
// order and, for a free, the first page of the block. Exactly one response
// beat on out_rsp follows for each request, with a status code and, for a
// successful allocate, the first page of the granted block.
// Requests are handled one at a time; the tree walks step one order level
// at a time through the mask memory, which has one read and one write port.
// An allocate with no space and a rejected request skip the walks.
// A finished response sits in an output register; the next request is taken
// while it waits, and a new response waits until out_rsp.ready frees it.
// After reset, and after a cfg_we write of the zone order while idle or
// clearing, a clearing sweep over every tree node rebuilds the tree with one
// free block; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [ORD_W-1:0] cfg_wdata,
  bpa_req_if.sink          in_req,
  bpa_rsp_if.source        out_rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_req.opcode),
    .in_block_order    (in_req.block_order),
    .in_page_index     (in_req.page_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_rsp.status),
    .out_granted_index (out_rsp.granted_index)
  );

endmodule

[sv/bpa_datapath.sv]
// ----------------------------------------------------------------------------
// bpa_datapath
// Order-mask tree memory and the walk registers. Each tree node holds one
// bit per order telling whether a free block of that order lies below it.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ORD_W-1:0]  cfg_wdata,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [ORD_W-1:0]  in_block_order,
  input  logic [PAGE_W-1:0] in_page_index,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output logic [STAT_W-1:0] out_status,
  output logic [PAGE_W-1:0] out_granted_index
);

  localparam int MW = ORDER_CAP + 1;
  localparam int NW = ORDER_CAP + 1;
  localparam int NN = 1 << NW;
  localparam int LW = $clog2(ORDER_CAP + 1);
  localparam int PW = ORDER_CAP;
  localparam int TOP_RST = (TOP_RESET > ORDER_CAP) ? ORDER_CAP : TOP_RESET;
  localparam logic [31:0] M32 = 32'(ORDER_CAP);

  logic [MW-1:0] mem [NN];
  logic [MW-1:0] rdata_r;
  logic [NW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  logic          wr_en;

  logic [LW-1:0] top_r;
  logic [NW-1:0] clr_cnt_r;
  logic          req_op_r, req_op_nxt;
  logic [LW-1:0] req_ord_r, req_ord_nxt;
  logic [NW-1:0] t_node_r, t_node_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [LW-1:0] fo_r, fo_nxt;
  logic [LW-1:0] split_r, split_nxt;
  logic [MW-1:0] mask_r, mask_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [STAT_W-1:0] res_status_r;
  logic [PAGE_W-1:0] res_granted_r;

  logic [31:0] top32, ord32, pg32, cur32, fo32, rord32, wide;
  logic [NW-1:0] root_node, t_in, sib;
  logic [MW-1:0] lvl_hot;
  logic          found;
  logic [LW-1:0] found_o;

  always_comb begin
    top32  = 32'(top_r);
    ord32  = 32'(in_block_order);
    pg32   = 32'(in_page_index);
    cur32  = 32'(cur_r);
    fo32   = 32'(fo_r);
    rord32 = 32'(req_ord_r);
    root_node = NW'(32'd1 << (M32 - top32));
    t_in      = NW'((32'd1 << (M32 - ord32)) + (pg32 >> ord32));
    sib       = cur_r ^ NW'(1);
    lvl_hot   = MW'(1) << level_r;
    // Lowest order at or above the request with a free block under the root.
    found   = 1'b0;
    found_o = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (rdata_r[i] && (32'(i) >= rord32) && (32'(i) <= top32)) begin
        found   = 1'b1;
        found_o = LW'(i);
      end
    end
    wide = ((cur32 - (32'd1 << (M32 - fo32))) << fo32);
  end

  always_comb begin
    sts.bad_req = (ord32 > top32) ||
                  ((in_opcode == OP_FREE) &&
                   (((pg32 & ((32'd1 << ord32) - 32'd1)) != 32'd0) ||
                    (pg32 >= (32'd1 << top32))));
    sts.is_free     = (in_opcode == OP_FREE);
    sts.clr_last    = (clr_cnt_r == {NW{1'b1}});
    sts.found       = found;
    sts.at_top      = (level_r == top_r);
    sts.at_fo       = (level_r == fo_r);
    sts.below_split = (level_r < split_r);
    sts.chk_hit     = (level_r == req_ord_r) ? (|rdata_r) : rdata_r[level_r];
    sts.buddy_free  = rdata_r[level_r];
  end

  // Memory port selection.
  always_comb begin
    rd_addr = cur_r;
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = '0;
    case (cmd.op)
      DP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = (clr_cnt_r == root_node) ? (MW'(1) << top_r) : '0;
      end
      DP_LOAD:    rd_addr = sts.is_free ? t_in : root_node;
      DP_DESC_RD: rd_addr = {cur_r[NW-2:0], 1'b0};
      DP_CHK_RD:  rd_addr = cur_r;
      DP_MRG_RD: begin
        rd_addr = sib;
        wr_en   = 1'b1;
        wr_addr = cur_r;
      end
      DP_MRG_TAKE: begin
        wr_en   = 1'b1;
        wr_addr = sib;
      end
      DP_UP_A: begin
        rd_addr = sib;
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = mask_r;
      end
      DP_UP_B: begin
        wr_en   = 1'b1;
        wr_addr = sib;
        wr_data = lvl_hot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    req_op_nxt  = req_op_r;
    req_ord_nxt = req_ord_r;
    t_node_nxt  = t_node_r;
    cur_nxt     = cur_r;
    level_nxt   = level_r;
    fo_nxt      = fo_r;
    split_nxt   = split_r;
    mask_nxt    = mask_r;
    page_nxt    = page_r;
    case (cmd.op)
      DP_LOAD: begin
        req_op_nxt  = in_opcode;
        req_ord_nxt = LW'(in_block_order);
        t_node_nxt  = t_in;
        split_nxt   = '0;
        if (in_opcode == OP_FREE) begin
          cur_nxt   = t_in;
          level_nxt = LW'(in_block_order);
        end else begin
          cur_nxt   = root_node;
          level_nxt = top_r;
        end
      end
      DP_ROOT_EVAL: begin
        fo_nxt    = found_o;
        split_nxt = found_o;
      end
      DP_DESC_STEP: begin
        cur_nxt   = {cur_r[NW-2:0], ~rdata_r[fo_r]};
        level_nxt = level_r - LW'(1);
      end
      DP_SPLIT_INIT: begin
        page_nxt  = PW'(wide);
        cur_nxt   = NW'(cur32 << (fo32 - rord32));
        level_nxt = req_ord_r;
        mask_nxt  = '0;
      end
      DP_CHK_UP, DP_MRG_TAKE: begin
        cur_nxt   = cur_r >> 1;
        level_nxt = level_r + LW'(1);
      end
      DP_MRG_INIT: begin
        cur_nxt   = t_node_r;
        level_nxt = req_ord_r;
      end
      DP_FINAL: mask_nxt = lvl_hot;
      DP_UP_B: begin
        mask_nxt  = mask_r | lvl_hot;
        cur_nxt   = cur_r >> 1;
        level_nxt = level_r + LW'(1);
      end
      DP_UP_W: begin
        mask_nxt  = mask_r | rdata_r;
        cur_nxt   = cur_r >> 1;
        level_nxt = level_r + LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= LW'(TOP_RST);
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        top_r     <= (32'(cfg_wdata) > M32) ? LW'(ORDER_CAP) : LW'(cfg_wdata);
        clr_cnt_r <= '0;
      end else if (cmd.op == DP_CLR) begin
        clr_cnt_r <= clr_cnt_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    req_op_r  <= req_op_nxt;
    req_ord_r <= req_ord_nxt;
    t_node_r  <= t_node_nxt;
    cur_r     <= cur_nxt;
    level_r   <= level_nxt;
    fo_r      <= fo_nxt;
    split_r   <= split_nxt;
    mask_r    <= mask_nxt;
    page_r    <= page_nxt;
    if (cmd.op == DP_RESULT) begin
      res_status_r  <= cmd.code;
      res_granted_r <= ((cmd.code == ST_OK) && (req_op_r == OP_ALLOC)) ?
                       PAGE_W'(32'(page_r)) : '0;
    end
  end

  assign out_status        = res_status_r;
  assign out_granted_index = res_granted_r;

endmodule

[sv/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: clearing sweep, allocate descent and split,
// free check and merge, and the upward mask repair.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROOT, S_DESC_RD, S_DESC_STEP, S_CHK, S_CHK_RD,
    S_MRG_RD, S_MRG_EV, S_UP_A, S_UP_B, S_UP_W, S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !cfg_we;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = DP_NOP;
    cmd.code      = code_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = DP_LOAD;
          if (sts.bad_req) begin
            code_nxt  = ST_BAD_REQ;
            state_nxt = S_FIN;
          end else if (sts.is_free) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        cmd.op = DP_ROOT_EVAL;
        if (sts.found) begin
          state_nxt = S_DESC_RD;
        end else begin
          code_nxt  = ST_NO_SPACE;
          state_nxt = S_FIN;
        end
      end
      S_DESC_RD: begin
        if (sts.at_fo) begin
          cmd.op    = DP_SPLIT_INIT;
          state_nxt = S_UP_A;
        end else begin
          cmd.op    = DP_DESC_RD;
          state_nxt = S_DESC_STEP;
        end
      end
      S_DESC_STEP: begin
        cmd.op    = DP_DESC_STEP;
        state_nxt = S_DESC_RD;
      end
      S_CHK: begin
        if (sts.chk_hit) begin
          code_nxt  = ST_DOUBLE_FREE;
          state_nxt = S_FIN;
        end else if (sts.at_top) begin
          cmd.op    = DP_MRG_INIT;
          state_nxt = S_MRG_RD;
        end else begin
          cmd.op    = DP_CHK_UP;
          state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        cmd.op    = DP_CHK_RD;
        state_nxt = S_CHK;
      end
      S_MRG_RD: begin
        if (sts.at_top) begin
          cmd.op    = DP_FINAL;
          state_nxt = S_UP_A;
        end else begin
          cmd.op    = DP_MRG_RD;
          state_nxt = S_MRG_EV;
        end
      end
      S_MRG_EV: begin
        if (sts.buddy_free) begin
          cmd.op    = DP_MRG_TAKE;
          state_nxt = S_MRG_RD;
        end else begin
          cmd.op    = DP_FINAL;
          state_nxt = S_UP_A;
        end
      end
      S_UP_A: begin
        cmd.op = DP_UP_A;
        if (sts.at_top) begin
          code_nxt  = ST_OK;
          state_nxt = S_FIN;
        end else if (sts.below_split) begin
          state_nxt = S_UP_B;
        end else begin
          state_nxt = S_UP_W;
        end
      end
      S_UP_B: begin
        cmd.op    = DP_UP_B;
        state_nxt = S_UP_A;
      end
      S_UP_W: begin
        cmd.op    = DP_UP_W;
        state_nxt = S_UP_A;
      end
      S_FIN: begin
        // The result register is loaded only once the previous beat is gone.
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && ((state_r == S_IDLE) || (state_r == S_CLEAR))) begin
      state_nxt = S_CLEAR;
      cmd.op    = DP_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sim/buddy_page_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb
// Self-checking bench for the buddy page allocator: a shadow free-block tree
// predicts status and granted page of every request, responses are checked
// in order, and both channels idle and stall at random over several zone
// sizes.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int MAX_ORD  = ORDER_CAP;
  localparam int TREE_SZ  = 2 << MAX_ORD;
  localparam int SETTLE   = 60;

  typedef struct {
    status_t           st;
    logic [PAGE_W-1:0] page;
  } grant_t;

  typedef struct {
    logic [ORD_W-1:0]  ord;
    logic [PAGE_W-1:0] page;
  } block_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ORD_W-1:0] cfg_wdata;

  bpa_req_if in_req();
  bpa_rsp_if out_rsp();

  buddy_page_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req.sink),
    .out_rsp   (out_rsp.source)
  );

  // Shadow state of the allocator.
  bit     free_tree [TREE_SZ];
  int     zone_order;
  grant_t pending_grants[$];
  block_t held_blocks[$];

  int errors;
  int n_sent;
  int n_checked;
  int n_ok_alloc;
  int n_ok_free;
  int n_no_space;
  int n_dbl_free;
  int n_bad_req;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_ack;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout after %0d responses", n_checked);
    $display("simulation failed");
    $finish;
  end

  function automatic int node_of(int ord, int page);
    return ((1 << (MAX_ORD - ord)) + (page >> ord)) & (TREE_SZ - 1);
  endfunction

  function automatic void set_zone(int value);
    zone_order = (value > MAX_ORD) ? MAX_ORD : value;
    foreach (free_tree[i]) free_tree[i] = 1'b0;
    free_tree[node_of(zone_order, 0)] = 1'b1;
    held_blocks.delete();
  endfunction

  function automatic bit overlaps_free(int ord, int page);
    for (int k = ord; k <= zone_order; k++) begin
      if (free_tree[node_of(k, page)]) return 1'b1;
    end
    for (int k = 0; k < ord; k++) begin
      for (int b = page >> k; b <= ((page + (1 << ord) - 1) >> k); b++) begin
        if (free_tree[node_of(k, b << k)]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow tree and returns the expected response.
  function automatic grant_t buddy_predict(logic op, int ord, int page);
    grant_t g;
    int     fo;
    int     fp;
    int     o;
    int     p;
    bit     found;
    g.st = ST_OK;
    g.page = '0;
    found = 1'b0;
    fo = 0;
    fp = 0;
    if (ord > zone_order) begin
      g.st = ST_BAD_REQ;
    end else if (op == OP_ALLOC) begin
      for (o = ord; o <= zone_order && !found; o++) begin
        for (int b = 0; b < (1 << (zone_order - o)); b++) begin
          if (free_tree[node_of(o, b << o)]) begin
            found = 1'b1;
            fo = o;
            fp = b << o;
            break;
          end
        end
      end
      if (!found) begin
        g.st = ST_NO_SPACE;
      end else begin
        free_tree[node_of(fo, fp)] = 1'b0;
        while (fo > ord) begin
          fo--;
          free_tree[node_of(fo, fp + (1 << fo))] = 1'b1;
        end
        g.page = fp;
      end
    end else begin
      if ((page & ((1 << ord) - 1)) != 0 || page >= (1 << zone_order)) begin
        g.st = ST_BAD_REQ;
      end else if (overlaps_free(ord, page)) begin
        g.st = ST_DOUBLE_FREE;
      end else begin
        o = ord;
        p = page;
        while (o < zone_order) begin
          if (!free_tree[node_of(o, p ^ (1 << o))]) break;
          free_tree[node_of(o, p ^ (1 << o))] = 1'b0;
          p &= ~(1 << o);
          o++;
        end
        free_tree[node_of(o, p)] = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Sends one request beat and records its expected response on acceptance.
  task automatic send_req(logic op, int ord, int page);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.opcode      <= op;
    in_req.block_order <= ord[ORD_W-1:0];
    in_req.page_index  <= page[PAGE_W-1:0];
    do @(posedge clk); while (!in_req.ready);
    g = buddy_predict(op, ord, page);
    pending_grants.push_back(g);
    n_sent++;
    if (g.st == ST_OK) begin
      if (op == OP_ALLOC) begin
        n_ok_alloc++;
        held_blocks.push_back('{ord[ORD_W-1:0], g.page});
      end else begin
        n_ok_free++;
      end
    end
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_zone(int value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[ORD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    set_zone(value);
  endtask

  // Response side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      n_checked++;
      if (pending_grants.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
      end else begin
        g = pending_grants.pop_front();
        case (g.st)
          ST_OK:          ;
          ST_NO_SPACE:    n_no_space++;
          ST_DOUBLE_FREE: n_dbl_free++;
          default:        n_bad_req++;
        endcase
        if (out_rsp.status !== g.st) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_rsp.status, g.st));
        end
        if (out_rsp.granted_index !== g.page) begin
          report_mismatch($sformatf("granted page %0d, expected %0d",
                                    out_rsp.granted_index, g.page));
        end
      end
    end
  end

  task automatic test_directed_edges();
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_ALLOC, 10, 0);
    send_req(OP_ALLOC, 11, 0);
    send_req(OP_FREE, 15, 0);
    send_req(OP_FREE, 0, 0);
    send_req(OP_FREE, 0, 5);
    send_req(OP_FREE, 10, 0);
    send_req(OP_ALLOC, 10, 1023);
    send_req(OP_ALLOC, 3, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_FREE, 3, 4);
    send_req(OP_FREE, 0, 1023);
    send_req(OP_FREE, 0, 1023);
    send_req(OP_FREE, 0, 8);
    send_req(OP_FREE, 1, 0);
    send_req(OP_FREE, 3, 0);
    send_req(OP_FREE, 10, 0);
    write_zone(3);
    send_req(OP_FREE, 0, 8);
    send_req(OP_ALLOC, 3, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_FREE, 3, 0);
    send_req(OP_FREE, 3, 0);
  endtask

  // Mostly well-formed allocate/free traffic, with a slice of noise.
  task automatic test_random_traffic(int count);
    block_t blk;
    int     r;
    int     ord;
    int     idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 48 || (r < 85 && held_blocks.size() == 0)) begin
        ord = ($urandom_range(9) == 0) ? $urandom_range(15)
                                       : $urandom_range(zone_order < 3 ? zone_order : 3);
        send_req(OP_ALLOC, ord, $urandom_range(1023));
      end else if (r < 85) begin
        idx = $urandom_range(held_blocks.size() - 1);
        blk = held_blocks[idx];
        held_blocks.delete(idx);
        send_req(OP_FREE, blk.ord, blk.page);
      end else if (r < 93) begin
        ord = $urandom_range(zone_order);
        send_req(OP_FREE, ord, ($urandom_range(1023) >> ord) << ord);
      end else begin
        send_req(OP_FREE, $urandom_range(15), $urandom_range(1023));
      end
    end
  endtask

  // The response side holds off while requests keep coming, then the
  // sender pauses until everything is answered before sending more.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    test_random_traffic(40);
    wait_drained();
    test_random_traffic(20);
  endtask

  initial begin
    int zones[7];
    zones = '{10, 4, 0, 15, 1, 7, 10};
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_ok_alloc = 0;
    n_ok_free = 0;
    n_no_space = 0;
    n_dbl_free = 0;
    n_bad_req = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.opcode = OP_ALLOC;
    in_req.block_order = '0;
    in_req.page_index = '0;
    out_rsp.ready = 1'b0;
    set_zone(TOP_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    for (int ph = 0; ph < 7; ph++) begin
      write_zone(zones[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      test_random_traffic(230);
    end
    test_backpressure();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("%0d requests over zone sizes 0 to 10, %0d responses checked:",
             n_sent, n_checked);
    $display("  granted %0d, freed %0d, no space %0d, double free %0d, rejected %0d, mismatches %0d",
             n_ok_alloc, n_ok_free, n_no_space, n_dbl_free, n_bad_req, errors);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
